[rtl/sdr_pkg.sv]
`default_nettype none
package sdr_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    KIND_INT_QUO  = 2'd0,
    KIND_INT_REM  = 2'd1,
    KIND_LONG_QUO = 2'd2,
    KIND_LONG_REM = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] dividend;
    logic signed [63:0] divisor;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               divide_by_zero;
  } out_word_t;

  // Per-item control that rides along with the divider stages.
  typedef struct packed {
    logic narrow;
    logic want_rem;
    logic a_neg;
    logic q_neg;
    logic dbz;
  } ctl_t;

endpackage
`default_nettype wire

[rtl/sdr_stage.sv]
`default_nettype none
// Restoring division over BITS quotient bits, one register stage.
module sdr_stage #(
  parameter int unsigned BITS = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    vld_in,
  input  wire sdr_pkg::ctl_t           ctl_in,
  input  wire logic [sdr_pkg::DataW-1:0] rem_in,
  input  wire logic [sdr_pkg::DataW-1:0] quo_in,
  input  wire logic [sdr_pkg::DataW-1:0] den_in,
  output logic                         vld_r,
  output sdr_pkg::ctl_t                ctl_r,
  output logic [sdr_pkg::DataW-1:0]    rem_r,
  output logic [sdr_pkg::DataW-1:0]    quo_r,
  output logic [sdr_pkg::DataW-1:0]    den_r
);
  localparam int unsigned W = sdr_pkg::DataW;

  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;

  always_comb begin
    logic [W:0] trial;
    rem_nxt = rem_in;
    quo_nxt = quo_in;
    for (int i = 0; i < int'(BITS); i++) begin
      trial = {rem_nxt, quo_nxt[W-1]} - {1'b0, den_in};
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
      end else begin
        rem_nxt = {rem_nxt[W-2:0], quo_nxt[W-1]};
      end
      quo_nxt = {quo_nxt[W-2:0], ~trial[W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_in;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      den_r <= den_in;
    end
  end
endmodule
`default_nettype wire

[rtl/signed_divide_remainder_32_64.sv]
`default_nettype none
// Channel | Ports                      | Word
// in      | in_valid in_ready in_data  | sdr_pkg::in_word_t
// out     | out_valid out_ready out_data | sdr_pkg::out_word_t
//
// One word accepted per cycle unless the output stalls; a word passes the
// prep register, the restoring-division stages and the output register.
// Reset clears every valid bit; data registers are not reset.
// A stall at the output holds the whole pipe in place; a word waiting in
// the output register blocks entry even while a bubble lies in the pipe.
module signed_divide_remainder_32_64 #(
  parameter int unsigned BITS_PER_STAGE = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sdr_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sdr_pkg::out_word_t      out_data
);
  localparam int unsigned W = sdr_pkg::DataW;
  localparam int unsigned NS = W / BITS_PER_STAGE;

  // Pipe advances when its tail is empty or being drained.
  logic en;

  // Stage 0: operand prep.
  logic         p_vld_r;
  sdr_pkg::ctl_t p_ctl_r;
  logic [W-1:0] p_ma_r;
  logic [W-1:0] p_mb_r;

  logic         s_vld [NS+1];
  sdr_pkg::ctl_t s_ctl [NS+1];
  logic [W-1:0] s_rem [NS+1];
  logic [W-1:0] s_quo [NS+1];
  logic [W-1:0] s_den [NS+1];

  logic         o_vld_r;
  sdr_pkg::out_word_t o_data_r;

  logic [W-1:0]  p_ma_nxt;
  logic [W-1:0]  p_mb_nxt;
  sdr_pkg::ctl_t p_ctl_nxt;

  assign en       = !o_vld_r || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         nar;
    nar = (in_data.kind == sdr_pkg::KIND_INT_QUO) || (in_data.kind == sdr_pkg::KIND_INT_REM);
    a = nar ? {{32{in_data.dividend[31]}}, in_data.dividend[31:0]} : in_data.dividend;
    b = nar ? {{32{in_data.divisor[31]}}, in_data.divisor[31:0]} : in_data.divisor;
    p_ma_nxt = a[W-1] ? (W'(0) - a) : a;
    p_mb_nxt = b[W-1] ? (W'(0) - b) : b;
    p_ctl_nxt.narrow   = nar;
    p_ctl_nxt.want_rem = in_data.kind[0];
    p_ctl_nxt.a_neg    = a[W-1];
    p_ctl_nxt.q_neg    = a[W-1] ^ b[W-1];
    p_ctl_nxt.dbz      = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ctl_r <= p_ctl_nxt;
      p_ma_r  <= p_ma_nxt;
      p_mb_r  <= p_mb_nxt;
    end
  end

  assign s_vld[0] = p_vld_r;
  assign s_ctl[0] = p_ctl_r;
  assign s_rem[0] = '0;
  assign s_quo[0] = p_ma_r;
  assign s_den[0] = p_mb_r;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    sdr_stage #(.BITS(BITS_PER_STAGE)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_in (s_vld[g]),
      .ctl_in (s_ctl[g]),
      .rem_in (s_rem[g]),
      .quo_in (s_quo[g]),
      .den_in (s_den[g]),
      .vld_r  (s_vld[g+1]),
      .ctl_r  (s_ctl[g+1]),
      .rem_r  (s_rem[g+1]),
      .quo_r  (s_quo[g+1]),
      .den_r  (s_den[g+1])
    );
  end

  // Final stage: sign fix, narrow, zero divisor.
  sdr_pkg::out_word_t o_data_nxt;
  always_comb begin
    logic [W-1:0]  mag;
    logic [W-1:0]  res;
    sdr_pkg::ctl_t c;
    c   = s_ctl[NS];
    mag = c.want_rem ? s_rem[NS] : s_quo[NS];
    res = (c.want_rem ? c.a_neg : c.q_neg) ? (W'(0) - mag) : mag;
    if (c.narrow) begin
      res = {{32{res[31]}}, res[31:0]};
    end
    if (c.dbz) begin
      res = '0;
    end
    o_data_nxt.result         = res;
    o_data_nxt.divide_by_zero = c.dbz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= s_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.result == '0)
    else $error("divide by zero with nonzero result");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
endmodule
`default_nettype wire
